>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/fmra_pkg.sv
`default_nettype none
package fmra_pkg;
	localparam int unsigned MAX_COLS_DEF = 1024;
	localparam int unsigned ROW_BITS_DEF = 16;

	localparam int unsigned COL_W = 10;
	localparam int unsigned VAL_W = 64;
	localparam int unsigned ROWNUM_W = 16;

	localparam logic [63:0] DNAN  = 64'h7FF8_0000_0000_0000;
	localparam logic [62:0] INF63 = 63'h7FF0_0000_0000_0000;

	// request kinds; the fourth code is ignored
	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_ROW  = 2'd1,
		REQ_ELEM = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_FETCH,
		T_RUN,
		T_EMIT
	} top_state_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_MUL,
		F_NORM,
		F_ALIGN,
		F_ADD,
		F_FIX,
		F_ROUND,
		F_PACK,
		F_DONE
	} fma_state_t;

	typedef struct packed {
		logic start;
	} fma_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} fma_stat_t;
endpackage
`default_nettype wire

>>> hdl/fmra_if.sv
`default_nettype none
// Request channel: load x, start row, matrix element.
interface fmra_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [9:0]  column;
	logic [63:0] value;
	logic        last;
	modport source(output valid, req_type, column, value, last, input ready);
	modport sink(input valid, req_type, column, value, last, output ready);
endinterface

// Result channel: finished y and its row number.
interface fmra_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] y_value;
	logic [15:0] row_number;
	modport source(output valid, y_value, row_number, input ready);
	modport sink(input valid, y_value, row_number, output ready);
endinterface
`default_nettype wire

>>> hdl/fp64_matvec_row_accumulate.sv
// Load and row-start requests are taken in idle; the block is ready again the next cycle.
// A matrix element holds the input through one vector read and the FMA. When an operand is
// NaN or infinity or a factor is zero the FMA goes straight to done, else it iterates (4 partial
// products of one 27x27 multiplier, normalize 8 or 1 bits a step, align, add, round).
// The last element of a row then moves y out, waiting while an older y is still not taken.
// arst_n clears the accumulator to +0.0, the row counter and control state; not the vector memory.
`default_nettype none
`include "assert_macros.svh"
module fp64_matvec_row_accumulate #(
	parameter int unsigned MAX_COLS = fmra_pkg::MAX_COLS_DEF,
	parameter int unsigned ROW_BITS = fmra_pkg::ROW_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	fmra_req_if.sink    req,
	fmra_rsp_if.source  rsp
);
	localparam int unsigned ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	fmra_pkg::top_state_t state_q, state_d;
	fmra_pkg::fma_ctl_t   fma_ctl;
	fmra_pkg::fma_stat_t  fma_stat;

	logic [63:0]         acc_q;
	logic [ROW_BITS-1:0] row_q;
	logic [63:0]         val_q;
	logic                last_q, colok_q;
	logic                rsp_valid_q;
	logic [63:0]         y_q;
	logic [15:0]         rown_q;

	logic                acc_req, col_ok, is_load, is_row, is_elem, emit;
	logic [63:0]         x_rd, fma_res;
	logic [ADDR_W-1:0]   ram_addr;

	// decode the incoming request
	always_comb begin
		acc_req = req.valid && req.ready;
		col_ok = 32'(req.column) < 32'(MAX_COLS);
		is_load = 1'b0;
		is_row = 1'b0;
		is_elem = 1'b0;
		unique case (req.req_type)
			fmra_pkg::REQ_LOAD: is_load = 1'b1;
			fmra_pkg::REQ_ROW:  is_row = 1'b1;
			fmra_pkg::REQ_ELEM: is_elem = 1'b1;
			default: begin
			end
		endcase
		ram_addr = ADDR_W'(req.column);
	end

	fmra_ram #(
		.WIDTH(64),
		.DEPTH(MAX_COLS)
	) u_xmem (
		.clk   (clk),
		.we    (acc_req && is_load && col_ok),
		.re    (acc_req && is_elem),
		.addr  (ram_addr),
		.wdata (req.value),
		.rdata (x_rd)
	);

	fmra_fma u_fma (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fma_ctl),
		.a      (val_q),
		.b      (colok_q ? x_rd : 64'd0),
		.c      (acc_q),
		.stat   (fma_stat),
		.result (fma_res)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmra_pkg::T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d = state_q;
		req.ready = 1'b0;
		fma_ctl.start = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			fmra_pkg::T_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && is_elem) begin
					state_d = fmra_pkg::T_FETCH;
				end
			end
			fmra_pkg::T_FETCH: begin
				fma_ctl.start = 1'b1;
				state_d = fmra_pkg::T_RUN;
			end
			fmra_pkg::T_RUN: begin
				if (fma_stat.done) begin
					state_d = last_q ? fmra_pkg::T_EMIT : fmra_pkg::T_IDLE;
				end
			end
			fmra_pkg::T_EMIT: begin
				if (!rsp_valid_q || rsp.ready) begin
					emit = 1'b1;
					state_d = fmra_pkg::T_IDLE;
				end
			end
			default: state_d = fmra_pkg::T_IDLE;
		endcase
	end

	// hold accumulator, row counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 64'd0;
			row_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc_req && is_row) begin
				acc_q <= req.value;
			end else if (state_q == fmra_pkg::T_RUN && fma_stat.done) begin
				acc_q <= fma_res;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
				row_q <= row_q + ROW_BITS'(1);
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// capture element request and result payload
	always_ff @(posedge clk) begin
		if (acc_req && is_elem) begin
			val_q <= req.value;
			last_q <= req.last;
			colok_q <= col_ok;
		end
		if (emit) begin
			y_q <= acc_q;
			rown_q <= 16'(row_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.y_value = y_q;
	assign rsp.row_number = rown_q;

	`ASSERT_PROP(a_start_busy, clk, arst_n, fma_ctl.start |=> fma_stat.busy, "FMA did not start")
	`ASSERT_NEVER(a_busy_ready, clk, arst_n, fma_stat.busy && req.ready, "request taken while FMA busy")
	`ASSERT_PROP(a_done_run, clk, arst_n, fma_stat.done |-> (state_q == fmra_pkg::T_RUN), "FMA done outside run")
	`ASSERT_PROP(a_emit_valid, clk, arst_n, emit |=> rsp.valid, "result lost after emit")
endmodule
`default_nettype wire

>>> hdl/fmra_ram.sv
`default_nettype none
module fmra_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic             re,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write or read one entry, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> hdl/fmra_fma.sv
`default_nettype none
module fmra_fma (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fmra_pkg::fma_ctl_t ctl,
	input  wire logic [63:0]        a,
	input  wire logic [63:0]        b,
	input  wire logic [63:0]        c,
	output fmra_pkg::fma_stat_t     stat,
	output logic      [63:0]        result
);
	fmra_pkg::fma_state_t state_q, state_d;

	logic [2:0]          cnt_q;
	logic [52:0]         ma_q, mb_q;
	logic [127:0]        pm_q, cm_q;
	logic signed [14:0]  ep_q, ec_q, ex_q;
	logic                sp_q, sc_q, zc_q, sign_q;
	logic [53:0]         pp_s1;
	logic [1:0]          psel_s1;
	logic [53:0]         m_q;
	logic [63:0]         res_q;

	// operand decode
	logic        sa, sb, sc, sp;
	logic [10:0] ea, eb, ec, eae, ebe, ece;
	logic [51:0] fa, fb, fc;
	logic        na, nb, nc, ia, ib, ic, za, zb, zc;
	logic        special;
	logic [63:0] special_val;

	always_comb begin
		sa = a[63]; sb = b[63]; sc = c[63];
		sp = sa ^ sb;
		ea = a[62:52]; eb = b[62:52]; ec = c[62:52];
		fa = a[51:0]; fb = b[51:0]; fc = c[51:0];
		eae = (ea == 11'd0) ? 11'd1 : ea;
		ebe = (eb == 11'd0) ? 11'd1 : eb;
		ece = (ec == 11'd0) ? 11'd1 : ec;
		ia = &ea; ib = &eb; ic = &ec;
		na = ia && |fa; nb = ib && |fb; nc = ic && |fc;
		za = ~|ea && ~|fa; zb = ~|eb && ~|fb; zc = ~|ec && ~|fc;
		special = 1'b1;
		special_val = c;
		priority if (na || nb || nc) begin
			special_val = fmra_pkg::DNAN;
		end else if (ia || ib) begin
			if (za || zb || (ic && sc != sp)) begin
				special_val = fmra_pkg::DNAN;
			end else begin
				special_val = {sp, fmra_pkg::INF63};
			end
		end else if (ic) begin
			special_val = c;
		end else if (za || zb) begin
			if (zc) begin
				special_val = {sp && sc, 63'd0};
			end else begin
				special_val = c;
			end
		end else begin
			special = 1'b0;
		end
	end

	// partial product select: lo*lo, lo*hi, hi*lo, hi*hi
	logic [26:0] mul_a, mul_b;
	logic [6:0]  pp_shift;

	always_comb begin
		mul_a = cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		mul_b = cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		unique case (psel_s1)
			2'd0:    pp_shift = 7'd0;
			2'd3:    pp_shift = 7'd54;
			default: pp_shift = 7'd27;
		endcase
	end

	// sticky right shift for alignment
	function automatic logic [127:0] shr_sticky(input logic [127:0] x, input logic [14:0] n);
		logic [127:0] r;
		logic [127:0] mask;
		if (n >= 15'd128) begin
			r = {127'd0, |x};
		end else begin
			r = x >> n[6:0];
			mask = (128'd1 << n[6:0]) - 128'd1;
			r[0] = r[0] | (|(x & mask));
		end
		return r;
	endfunction

	logic signed [14:0] d_exp;
	logic [14:0]        d_mag;
	logic [127:0]       al_val;
	logic               p_big8, c_big8;

	always_comb begin
		d_exp = ep_q - ec_q;
		d_mag = d_exp[14] ? 15'(-d_exp) : d_exp;
		al_val = shr_sticky(d_exp[14] ? pm_q : cm_q, d_mag);
		p_big8 = ~|pm_q[125:118];
		c_big8 = ~|cm_q[125:118];
	end

	// rounding position and guard bits
	logic signed [14:0] t_exp, s_exp;
	logic [7:0]         nsh, nm1;
	logic [127:0]       rnd_sh, rnd_mask;
	logic               rnd_bit, rnd_stk;

	always_comb begin
		t_exp = -15'sd1074 - ep_q;
		s_exp = (t_exp > 15'sd73) ? t_exp : 15'sd73;
		nsh = (s_exp >= 15'sd129) ? 8'd129 : s_exp[7:0];
		nm1 = nsh - 8'd1;
		rnd_sh = pm_q >> nsh;
		rnd_bit = nm1[7] ? 1'b0 : pm_q[nm1[6:0]];
		rnd_mask = nm1[7] ? '1 : ((128'd1 << nm1[6:0]) - 128'd1);
		rnd_stk = |(pm_q & rnd_mask);
	end

	logic signed [14:0] e_m1;
	logic [63:0]        pack_bits;

	always_comb begin
		e_m1 = ex_q - 15'sd1;
		pack_bits = ({53'd0, e_m1[10:0]} << 52) + {10'd0, m_q};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmra_pkg::F_IDLE;
			cnt_q <= 3'd0;
		end else begin
			state_q <= state_d;
			if (state_q == fmra_pkg::F_MUL) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= 3'd0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fmra_pkg::F_IDLE: begin
				if (ctl.start) begin
					state_d = special ? fmra_pkg::F_DONE : fmra_pkg::F_MUL;
				end
			end
			fmra_pkg::F_MUL: begin
				if (cnt_q == 3'd4) begin
					state_d = fmra_pkg::F_NORM;
				end
			end
			fmra_pkg::F_NORM: begin
				if (pm_q[125] && (zc_q || cm_q[125])) begin
					state_d = zc_q ? fmra_pkg::F_ROUND : fmra_pkg::F_ALIGN;
				end
			end
			fmra_pkg::F_ALIGN: state_d = fmra_pkg::F_ADD;
			fmra_pkg::F_ADD: begin
				state_d = (sp_q != sc_q && pm_q == cm_q) ? fmra_pkg::F_DONE : fmra_pkg::F_FIX;
			end
			fmra_pkg::F_FIX: begin
				if (!pm_q[126] && pm_q[125]) begin
					state_d = fmra_pkg::F_ROUND;
				end
			end
			fmra_pkg::F_ROUND: state_d = fmra_pkg::F_PACK;
			fmra_pkg::F_PACK:  state_d = fmra_pkg::F_DONE;
			fmra_pkg::F_DONE:  state_d = fmra_pkg::F_IDLE;
			default:           state_d = fmra_pkg::F_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			fmra_pkg::F_IDLE: begin
				res_q <= special_val;
				ma_q <= {|ea, fa};
				mb_q <= {|eb, fb};
				pm_q <= '0;
				cm_q <= {75'd0, |ec, fc};
				ep_q <= $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 15'sd2150;
				ec_q <= $signed({4'd0, ece}) - 15'sd1075;
				sp_q <= sp;
				sc_q <= sc;
				zc_q <= zc;
				sign_q <= sp;
			end
			fmra_pkg::F_MUL: begin
				if (cnt_q < 3'd4) begin
					pp_s1 <= mul_a * mul_b;
					psel_s1 <= cnt_q[1:0];
				end
				if (cnt_q != 3'd0) begin
					pm_q <= pm_q + (128'(pp_s1) << pp_shift);
				end
			end
			fmra_pkg::F_NORM: begin
				if (!pm_q[125]) begin
					pm_q <= p_big8 ? (pm_q << 8) : (pm_q << 1);
					ep_q <= ep_q - (p_big8 ? 15'sd8 : 15'sd1);
				end
				if (!zc_q && !cm_q[125]) begin
					cm_q <= c_big8 ? (cm_q << 8) : (cm_q << 1);
					ec_q <= ec_q - (c_big8 ? 15'sd8 : 15'sd1);
				end
			end
			fmra_pkg::F_ALIGN: begin
				if (d_exp[14]) begin
					pm_q <= al_val;
					ep_q <= ec_q;
				end else begin
					cm_q <= al_val;
				end
			end
			fmra_pkg::F_ADD: begin
				if (sp_q == sc_q) begin
					pm_q <= pm_q + cm_q;
				end else if (pm_q == cm_q) begin
					res_q <= 64'd0;
				end else if (pm_q > cm_q) begin
					pm_q <= pm_q - cm_q;
				end else begin
					pm_q <= cm_q - pm_q;
					sign_q <= sc_q;
				end
			end
			fmra_pkg::F_FIX: begin
				priority if (pm_q[126]) begin
					pm_q <= {1'b0, pm_q[127:2], pm_q[1] | pm_q[0]};
					ep_q <= ep_q + 15'sd1;
				end else if (!pm_q[125]) begin
					pm_q <= p_big8 ? (pm_q << 8) : (pm_q << 1);
					ep_q <= ep_q - (p_big8 ? 15'sd8 : 15'sd1);
				end
			end
			fmra_pkg::F_ROUND: begin
				m_q <= rnd_sh[53:0] + {53'd0, rnd_bit && (rnd_stk || rnd_sh[0])};
				ex_q <= s_exp + ep_q + 15'sd1075;
			end
			fmra_pkg::F_PACK: begin
				if (ex_q > 15'sd2046 || pack_bits[62:0] >= fmra_pkg::INF63) begin
					res_q <= {sign_q, fmra_pkg::INF63};
				end else begin
					res_q <= {sign_q, pack_bits[62:0]};
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != fmra_pkg::F_IDLE);
	assign stat.done = (state_q == fmra_pkg::F_DONE);
	assign result = res_q;
endmodule
`default_nettype wire

>>> dv/fp64_matvec_row_accumulate_test.sv
`timescale 1ns / 1ps
module fp64_matvec_row_accumulate_test;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] ONE = 64'h3FF0_0000_0000_0000;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_GOAL = 850;

	typedef struct {
		logic [1:0]  kind;
		logic [9:0]  col;
		logic [63:0] val;
		logic        last;
		bit          typed;
		logic [63:0] y;
	} dir_row_t;

	typedef struct {
		logic [63:0] y;
		logic [15:0] row;
	} y_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fmra_req_if req();
	fmra_rsp_if rsp();

	fp64_matvec_row_accumulate i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [63:0] x_mem [1024];
	bit          x_written [1024];
	logic [63:0] acc_y;
	logic [15:0] rows_done;

	y_exp_t y_pending [$];
	dir_row_t dir_tab [22];
	int errors = 0;
	int items_sent = 0;
	int rows_seen = 0;
	int nan_rows = 0;
	int idle_cnt = 0;
	bit calm = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int msb_of(input logic [127:0] v);
		int n;
		n = -1;
		for (int k = 0; k < 128; k++)
			if (v[k]) n = k;
		return n;
	endfunction

	// any of bits 0 .. n-1 set
	function automatic bit bits_below(input logic [127:0] v, input int n);
		logic [127:0] mask;
		if (n <= 0) return 1'b0;
		if (n >= 128) return |v;
		mask = {128{1'b1}} >> (128 - n);
		return |(v & mask);
	endfunction

	function automatic logic [127:0] shr_sticky(input logic [127:0] v, input int n);
		logic [127:0] r;
		if (n <= 0) return v;
		r = (n >= 128) ? 128'd0 : (v >> n);
		if (bits_below(v, n)) r[0] = 1'b1;
		return r;
	endfunction

	// round magnitude v * 2^ex to binary64, nearest-even
	function automatic logic [63:0] round_dp(input bit sgn, input logic [127:0] v, input int ex);
		int s, t, e;
		logic [127:0] sr;
		logic [63:0] m, bits;
		s = msb_of(v) - 52;
		t = -1074 - ex;
		if (t > s) s = t;
		if (s <= 0) begin
			m = 64'(v << (-s));
		end else begin
			sr = (s >= 128) ? 128'd0 : (v >> s);
			m = sr[63:0];
			if (s - 1 < 128 && v[s-1] && (bits_below(v, s - 1) || m[0])) m++;
		end
		e = s + ex + 1075;
		if (e > 2046) return {sgn, POS_INF[62:0]};
		bits = (64'(e - 1) << 52) + m;
		if (bits >= POS_INF) bits = POS_INF;
		return {sgn, bits[62:0]};
	endfunction

	// a * b + c with one rounding
	function automatic logic [63:0] fma_dp(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] c);
		bit sc, sp, za, zb, zc, sgn;
		int ea, eb, ec, ep, eq, e, sh;
		logic [63:0] ma, mb, mc;
		logic [127:0] p, q, r;
		sc = c[63];
		sp = a[63] ^ b[63];
		ea = a[62:52];
		eb = b[62:52];
		ec = c[62:52];
		za = ea == 0 && a[51:0] == 0;
		zb = eb == 0 && b[51:0] == 0;
		zc = ec == 0 && c[51:0] == 0;
		if ((ea == 2047 && a[51:0] != 0) || (eb == 2047 && b[51:0] != 0) ||
				(ec == 2047 && c[51:0] != 0)) return fmra_pkg::DNAN;
		if (ea == 2047 || eb == 2047) begin
			if (za || zb) return fmra_pkg::DNAN;
			if (ec == 2047 && sc != sp) return fmra_pkg::DNAN;
			return {sp, POS_INF[62:0]};
		end
		if (ec == 2047) return c;
		if (za || zb) begin
			if (zc) return (sp == sc) ? {sp, 63'd0} : 64'd0;
			return c;
		end
		ma = {11'd0, ea != 0, a[51:0]};
		mb = {11'd0, eb != 0, b[51:0]};
		mc = {11'd0, ec != 0, c[51:0]};
		p = 128'(ma) * 128'(mb);
		ep = (ea != 0 ? ea : 1) - 1075 + (eb != 0 ? eb : 1) - 1075;
		if (zc) return round_dp(sp, p, ep);
		sh = 125 - msb_of(p);
		p = p << sh;
		ep -= sh;
		q = 128'(mc);
		eq = (ec != 0 ? ec : 1) - 1075;
		sh = 125 - msb_of(q);
		q = q << sh;
		eq -= sh;
		if (ep >= eq) begin
			q = shr_sticky(q, ep - eq);
			e = ep;
		end else begin
			p = shr_sticky(p, eq - ep);
			e = eq;
		end
		if (sp == sc) begin
			r = p + q;
			sgn = sp;
		end else begin
			if (p == q) return 64'd0;
			if (p > q) begin
				r = p - q;
				sgn = sp;
			end else begin
				r = q - p;
				sgn = sc;
			end
		end
		return round_dp(sgn, r, e);
	endfunction

	// advance the predictor by one accepted request
	task automatic predict_row_update(input logic [1:0] kind, input logic [9:0] col,
			input logic [63:0] val, input logic last, input bit typed, input logic [63:0] y);
		y_exp_t ex;
		case (kind)
			fmra_pkg::REQ_LOAD: begin
				x_mem[col] = val;
				x_written[col] = 1'b1;
			end
			fmra_pkg::REQ_ROW: acc_y = val;
			fmra_pkg::REQ_ELEM: begin
				acc_y = fma_dp(val, x_mem[col], acc_y);
				if (last) begin
					ex.y = typed ? y : acc_y;
					ex.row = rows_done;
					y_pending.push_back(ex);
					rows_done++;
				end
			end
			default: ;
		endcase
	endtask

	// drive one request, idling at random, and wait for acceptance
	task automatic send_request(input logic [1:0] kind, input logic [9:0] col,
			input logic [63:0] val, input logic last, input bit typed = 1'b0,
			input logic [63:0] y = 64'd0);
		while (!calm && $urandom_range(0, 99) < 20) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= kind;
		req.column <= col;
		req.value <= val;
		req.last <= last;
		do @(posedge clk); while (!req.ready);
		predict_row_update(kind, col, val, last, typed, y);
		items_sent++;
	endtask

	function automatic logic [63:0] rand_double();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0, 1, 2, 3, 4, 5: v[62:52] = 11'(1023 - 20 + $urandom_range(0, 40));
			6: v[62:52] = 11'd0;
			7: v[62:0] = 63'd0;
			8: v[62:0] = $urandom_range(0, 3) == 0 ? fmra_pkg::DNAN[62:0] : POS_INF[62:0];
			9: v[62:52] = $urandom_range(0, 1) ? 11'd2046 : 11'd1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [9:0] pick_loaded_col();
		logic [9:0] c;
		do c = 10'($urandom_range(0, 1023)); while (!x_written[c]);
		return c;
	endfunction

	// check results against the oldest expectation
	always @(posedge clk) begin
		y_exp_t ex;
		if (arst_n && rsp.valid && rsp.ready) begin
			rows_seen++;
			if (rsp.y_value == fmra_pkg::DNAN) nan_rows++;
			if (y_pending.size() == 0) begin
				report_mismatch($sformatf("unexpected y %h row %0d", rsp.y_value,
					rsp.row_number));
			end else begin
				ex = y_pending.pop_front();
				if (rsp.y_value !== ex.y)
					report_mismatch($sformatf("row %0d y %h, want %h", ex.row,
						rsp.y_value, ex.y));
				if (rsp.row_number !== ex.row)
					report_mismatch($sformatf("row number %0d, want %0d",
						rsp.row_number, ex.row));
			end
		end
	end

	// stall the result side at random
	always @(posedge clk)
		rsp.ready <= calm || $urandom_range(0, 99) >= 20;

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int n;
		logic [1:0] k;
		req.valid = 1'b0;
		req.req_type = REQ_NONE;
		req.column = '0;
		req.value = '0;
		req.last = 1'b0;
		rsp.ready = 1'b0;
		for (int i = 0; i < 1024; i++) begin
			x_mem[i] = '0;
			x_written[i] = 1'b0;
		end
		acc_y = '0;
		rows_done = '0;

		dir_tab = '{
			'{fmra_pkg::REQ_LOAD, 10'd0, ONE, 1'b0, 1'b0, 64'd0},
			// element right after reset accumulates into +0.0
			'{fmra_pkg::REQ_ELEM, 10'd0, 64'h4000_0000_0000_0000, 1'b1, 1'b1,
				64'h4000_0000_0000_0000},
			'{fmra_pkg::REQ_LOAD, 10'd1023, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'd0},
			'{fmra_pkg::REQ_LOAD, 10'd1, POS_INF, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_LOAD, 10'd2, 64'h0000_0000_0000_0001, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_LOAD, 10'd3, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'd0},
			// infinity times zero
			'{fmra_pkg::REQ_ROW, 10'd0, POS_INF, 1'b1, 1'b0, 64'd0},
			'{fmra_pkg::REQ_ELEM, 10'd1, 64'd0, 1'b1, 1'b1, fmra_pkg::DNAN},
			// infinity minus infinity
			'{fmra_pkg::REQ_ROW, 10'd5, POS_INF, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_ELEM, 10'd1, 64'hBFF0_0000_0000_0000, 1'b1, 1'b1, fmra_pkg::DNAN},
			'{REQ_NONE, 10'h3FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'd0},
			// negative zeros stay negative, opposite zeros give +0
			'{fmra_pkg::REQ_ROW, 10'd0, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_ELEM, 10'd3, ONE, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
			'{fmra_pkg::REQ_ROW, 10'd0, 64'd0, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_ELEM, 10'd3, ONE, 1'b1, 1'b1, 64'd0},
			// overflow to infinity
			'{fmra_pkg::REQ_ELEM, 10'd1023, ONE, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_ELEM, 10'd1023, ONE, 1'b1, 1'b1, POS_INF},
			// subnormal operand
			'{fmra_pkg::REQ_ROW, 10'd0, 64'h0000_0000_0000_0001, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_ELEM, 10'd2, 64'h3FE0_0000_0000_0000, 1'b1, 1'b0, 64'd0},
			// NaN initial y
			'{fmra_pkg::REQ_ROW, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'd0},
			'{fmra_pkg::REQ_ELEM, 10'd0, ONE, 1'b1, 1'b1, fmra_pkg::DNAN},
			// zero factor with a NaN accumulator
			'{fmra_pkg::REQ_ELEM, 10'd0, 64'h0, 1'b1, 1'b0, 64'd0}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_request(dir_tab[i].kind, dir_tab[i].col, dir_tab[i].val, dir_tab[i].last,
				dir_tab[i].typed, dir_tab[i].y);
		send_request(fmra_pkg::REQ_ROW, 10'd0, 64'hBFF0_0000_0000_0000, 1'b0);
		send_request(fmra_pkg::REQ_ELEM, 10'd0, ONE, 1'b1, 1'b1, 64'd0);

		// fill a spread of x entries with random content
		for (int i = 0; i < 40; i++)
			send_request(fmra_pkg::REQ_LOAD, 10'($urandom_range(0, 1023)), rand_double(),
				1'($urandom));

		while (items_sent < ITEM_GOAL) begin
			calm = items_sent >= 300 && items_sent < 420;
			// hold off until every y has come back
			if (items_sent >= 500 && items_sent < 510)
				while (y_pending.size() != 0) begin
					req.valid <= 1'b0;
					@(posedge clk);
				end
			case ($urandom_range(0, 9))
				0: send_request(fmra_pkg::REQ_LOAD, 10'($urandom_range(0, 1023)),
					rand_double(), 1'($urandom));
				1: begin
					k = $urandom_range(0, 1) ? REQ_NONE : fmra_pkg::REQ_ROW;
					send_request(k, 10'($urandom), rand_double(), 1'($urandom));
				end
				default: begin
					// well-formed row, sometimes without a row start
					if ($urandom_range(0, 7) != 0)
						send_request(fmra_pkg::REQ_ROW, 10'($urandom), rand_double(),
							1'($urandom));
					n = $urandom_range(1, 6);
					for (int j = 0; j < n; j++)
						send_request(fmra_pkg::REQ_ELEM, pick_loaded_col(), rand_double(),
							j == n - 1);
				end
			endcase
		end
		calm = 1'b0;
		req.valid <= 1'b0;

		while (y_pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d requests, %0d rows returned (%0d NaN)", items_sent,
			rows_seen, nan_rows);
		$display("directed extremes, specials, random rows with stalls on both sides");
		if (errors == 0 && y_pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
